### hw/rtl/itpg_pkg.sv
// Shared types, register codes, reset values and sine table arithmetic for the IQ pattern generator.
package itpg_pkg;

  localparam int unsigned DEF_TABLE_INDEX_BITS = 12;
  localparam int unsigned NUM_SLOTS = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [1:0] REG_TWO_CHANNEL  = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP   = 2'd2;
  localparam logic [1:0] REG_AMPLITUDE    = 2'd3;

  localparam logic        RST_PATTERN_MODE = 1'b0;
  localparam logic        RST_TWO_CHANNEL  = 1'b1;
  localparam logic [31:0] RST_PHASE_STEP   = 32'd69905067;
  localparam logic [14:0] RST_AMPLITUDE    = 15'd6554;
  localparam logic [14:0] AMP_MAX          = 15'd31130;

  // pi/2 in unsigned Q2.62.
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic        pattern_mode;
    logic        two_channel;
    logic [31:0] phase_step;
    logic [14:0] amplitude_q15;
  } cfg_t;

  // (a*b) >> 62 for Q2.62 operands, kept to 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, one quotient bit per step.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = 64'd0;
    rem = 65'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Rounded 32767*sin of quarter-wave entry k for a table of 2^idx_bits entries.
  // Evaluated only while the table constant is elaborated.
  function automatic logic [14:0] sine_mag(input int unsigned k, input int unsigned idx_bits);
    logic [63:0] whole;
    logic [63:0] part;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] n;
    logic        minus;
    whole = HALF_PI_Q62 >> (idx_bits - 2);
    part  = HALF_PI_Q62 & ((64'd1 << (idx_bits - 2)) - 64'd1);
    x     = whole * 64'(k) + ((part * 64'(k)) >> (idx_bits - 2));
    x2    = mul_q62(x, x);
    term  = x;
    pos   = 64'd0;
    neg   = 64'd0;
    n     = 64'd1;
    minus = 1'b0;
    while (term != 64'd0) begin
      if (minus) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      term  = div_u64(mul_q62(term, x2), (n + 64'd1) * (n + 64'd2));
      n     = n + 64'd2;
      minus = !minus;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    s = ((s >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

endpackage

### hw/rtl/itpg_sine_rom.sv
// Quarter-wave sine magnitude ROM with two registered read ports.
module itpg_sine_rom #(
  parameter int unsigned TABLE_INDEX_BITS = 12
) (
  input  logic                          clk,
  input  logic [TABLE_INDEX_BITS-2:0]   addr_a,
  input  logic [TABLE_INDEX_BITS-2:0]   addr_b,
  output logic [14:0]                   data_a,
  output logic [14:0]                   data_b
);
  import itpg_pkg::*;

  localparam int unsigned QUARTER = 1 << (TABLE_INDEX_BITS - 2);

  typedef logic [14:0] quarter_tab_t [QUARTER+1];

  function automatic quarter_tab_t build_tab();
    quarter_tab_t t;
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      t[k] = sine_mag(k, TABLE_INDEX_BITS);
    end
    return t;
  endfunction

  localparam quarter_tab_t SINE_TAB = build_tab();

  always_ff @(posedge clk) begin
    data_a <= SINE_TAB[addr_a];
    data_b <= SINE_TAB[addr_b];
  end

endmodule

### hw/rtl/itpg_lane.sv
// One output slot: phase multiply, folded sine lookup, amplitude scaling and ramp path.
module itpg_lane #(
  parameter int unsigned TABLE_INDEX_BITS = 12
) (
  input  logic           clk,
  input  itpg_pkg::cfg_t cfg,
  input  logic [31:0]    sample_n,
  input  logic           channel,
  output logic [31:0]    slot_word
);
  import itpg_pkg::*;

  localparam int unsigned AW      = TABLE_INDEX_BITS - 1;
  localparam int unsigned QUARTER = 1 << (TABLE_INDEX_BITS - 2);

  // Stage 1: phase product and ramp value.
  logic [31:0] prod1;
  logic        ch1;
  logic [14:0] ramp1;

  always_ff @(posedge clk) begin
    prod1 <= sample_n * cfg.phase_step;
    ch1   <= channel;
    ramp1 <= sample_n[14:0] + {sample_n[6:0], 8'd0} + {1'b0, channel, 13'd0};
  end

  // Table address for sine (Q) and cosine (I), folded onto the quarter wave.
  logic [31:0]                 phase;
  logic [TABLE_INDEX_BITS-1:0] q_idx;
  logic [TABLE_INDEX_BITS-1:0] i_idx;
  logic [AW-1:0]               q_j;
  logic [AW-1:0]               i_j;
  logic [AW-1:0]               q_addr;
  logic [AW-1:0]               i_addr;

  always_comb begin
    phase  = prod1 + {1'b0, ch1, 30'd0};
    q_idx  = phase[31 -: TABLE_INDEX_BITS];
    i_idx  = q_idx + TABLE_INDEX_BITS'(QUARTER);
    q_j    = q_idx[AW-1:0];
    i_j    = i_idx[AW-1:0];
    q_addr = (q_j > AW'(QUARTER)) ? (~q_j + AW'(1)) : q_j;
    i_addr = (i_j > AW'(QUARTER)) ? (~i_j + AW'(1)) : i_j;
  end

  // Stage 2: table read; the upper half of the wave is negative.
  logic [14:0] rom_q;
  logic [14:0] rom_i;
  logic        sign_q2;
  logic        sign_i2;
  logic [14:0] ramp2;

  itpg_sine_rom #(
    .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
  ) u_rom (
    .clk   (clk),
    .addr_a(q_addr),
    .addr_b(i_addr),
    .data_a(rom_q),
    .data_b(rom_i)
  );

  always_ff @(posedge clk) begin
    sign_q2 <= q_idx[TABLE_INDEX_BITS-1];
    sign_i2 <= i_idx[TABLE_INDEX_BITS-1];
    ramp2   <= ramp1;
  end

  // Stage 3: magnitude scaling, truncated toward zero by working on magnitudes.
  logic [29:0] amp_q;
  logic [29:0] amp_i;
  logic [14:0] mag_q3;
  logic [14:0] mag_i3;
  logic        sign_q3;
  logic        sign_i3;
  logic [14:0] ramp3;

  assign amp_q = {15'd0, rom_q} * {15'd0, cfg.amplitude_q15};
  assign amp_i = {15'd0, rom_i} * {15'd0, cfg.amplitude_q15};

  always_ff @(posedge clk) begin
    mag_q3  <= amp_q[29:15];
    mag_i3  <= amp_i[29:15];
    sign_q3 <= sign_q2;
    sign_i3 <= sign_i2;
    ramp3   <= ramp2;
  end

  logic [15:0] tone_q;
  logic [15:0] tone_i;
  logic [15:0] ramp_q;

  always_comb begin
    tone_q    = sign_q3 ? 16'(-{1'b0, mag_q3}) : {1'b0, mag_q3};
    tone_i    = sign_i3 ? 16'(-{1'b0, mag_i3}) : {1'b0, mag_i3};
    ramp_q    = 16'(-{1'b0, ramp3});
    slot_word = cfg.pattern_mode ? {1'b0, ramp3, ramp_q} : {tone_i, tone_q};
  end

endmodule

### hw/rtl/iq_test_pattern_word_generator.sv
// Top level of the IQ test pattern word generator: registers, slot indexing and output word.
//
//  channel   signals                                   direction
//  command   start, busy, sample_index                 in (busy out)
//  result    done, slot0_word .. slot3_word            out, one-cycle strobe
//  config    cfg_we, cfg_index, cfg_wdata              in, write only
//
// A new sample index is taken in every cycle while busy is low; the word appears on done after
// the input register, the phase multiplier, the registered sine table read, the amplitude
// multiplier and the output register.
// Reset clears the valid pipeline and loads the register defaults; busy is high in reset only.
// The receiver cannot stall, so nothing inside the pipeline ever waits.
module iq_test_pattern_word_generator #(
  parameter int unsigned TABLE_INDEX_BITS = itpg_pkg::DEF_TABLE_INDEX_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_index,
  output logic        done,
  output logic [31:0] slot0_word,
  output logic [31:0] slot1_word,
  output logic [31:0] slot2_word,
  output logic [31:0] slot3_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import itpg_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_mode  <= RST_PATTERN_MODE;
      cfg.two_channel   <= RST_TWO_CHANNEL;
      cfg.phase_step    <= RST_PHASE_STEP;
      cfg.amplitude_q15 <= RST_AMPLITUDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_MODE: cfg.pattern_mode <= cfg_wdata[0];
        REG_TWO_CHANNEL:  cfg.two_channel  <= cfg_wdata[0];
        REG_PHASE_STEP:   cfg.phase_step   <= cfg_wdata;
        REG_AMPLITUDE: begin
          cfg.amplitude_q15 <= (cfg_wdata[14:0] > AMP_MAX) ? AMP_MAX : cfg_wdata[14:0];
        end
      endcase
    end
  end

  assign busy = rst;

  logic       accept;
  logic [3:0] vld;
  logic [31:0] n1;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], accept};
      done <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n1 <= sample_index;
    end
  end

  // Two-channel words carry both channels at n and n+1; otherwise channel 0 at n..n+3.
  logic [31:0] lane_n  [NUM_SLOTS];
  logic        lane_ch [NUM_SLOTS];
  logic [31:0] lane_word [NUM_SLOTS];

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (cfg.two_channel) begin
        lane_n[s]  = n1 + 32'(s / 2);
        lane_ch[s] = 1'(s);
      end else begin
        lane_n[s]  = n1 + 32'(s);
        lane_ch[s] = 1'b0;
      end
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
    itpg_lane #(
      .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
    ) u_lane (
      .clk      (clk),
      .cfg      (cfg),
      .sample_n (lane_n[g]),
      .channel  (lane_ch[g]),
      .slot_word(lane_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (vld[3]) begin
      slot0_word <= lane_word[0];
      slot1_word <= lane_word[1];
      slot2_word <= lane_word[2];
      slot3_word <= lane_word[3];
    end
  end

  // Every accepted transaction yields exactly one result.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted transaction produced no result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result without a matching transaction");

  a_pipe_tracks_done: assert property (@(posedge clk) disable iff (rst)
    vld[3] |=> done)
    else $error("valid pipeline and result strobe disagree");

endmodule
